// ===== rtl/perf_counter_delta_accumulator_defines.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the counter delta accumulator
// ---------------------------------------------------------------------------
`ifndef PERF_COUNTER_DELTA_ACCUMULATOR_DEFINES_SVH
`define PERF_COUNTER_DELTA_ACCUMULATOR_DEFINES_SVH

// check an implication on every clock edge outside reset
`define PCDA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check an implication in the following cycle
`define PCDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pcda_pkg.sv =====
// ---------------------------------------------------------------------------
// pcda_pkg
// shared types and constants of the counter delta accumulator
// ---------------------------------------------------------------------------
package pcda_pkg;

   localparam logic [1:0] MODE_ACCUM = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   // mode with no action and no result
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam logic CSR_REPORT_FORMAT = 1'b0;
   localparam logic CSR_TICK_FREQ     = 1'b1;

   localparam logic [31:0] TICK_FREQ_RESET = 32'd12500000;
   localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  word_pos;
      logic [31:0] start_word;
      logic [31:0] end_word;
      logic [7:0]  start_high;
      logic [7:0]  end_high;
      logic        last_word;
      logic [5:0]  counter_index;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [63:0] first_time_ns;
      logic [63:0] last_time_ns;
      logic [63:0] counter_value;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ACC_WAIT,
      ST_READ_WAIT,
      ST_SCALE_INIT,
      ST_SCALE_MUL,
      ST_SCALE_DIV,
      ST_SCALE_ADD,
      ST_RESP,
      ST_INIT
   } state_type;

   // request to the scaling unit
   typedef struct packed {
      logic        start;
      logic [31:0] ticks;
      logic [31:0] freq;
   } scale_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] ns;
   } scale_rsp_type;

   // slot lookup: returns {valid, wide, slot}
   function automatic logic [7:0] slot_of(input logic fmt, input logic [5:0] pos);
      logic [7:0] r;
      r = 8'd0;
      if (pos == 6'd1) begin
         r = {2'b10, 6'd0};
      end else if (fmt) begin
         if (pos >= 6'd3) r = {2'b10, pos - 6'd2};
      end else if (pos == 6'd3) begin
         r = {2'b10, 6'd1};
      end else if (pos >= 6'd4 && pos <= 6'd35) begin
         r = {2'b11, pos - 6'd2};
      end else if (pos >= 6'd36 && pos <= 6'd39) begin
         r = {2'b10, pos - 6'd2};
      end else if (pos >= 6'd48) begin
         r = {2'b10, pos - 6'd10};
      end
      return r;
   endfunction

endpackage

// ===== rtl/pcda_stream_if.sv =====
// ---------------------------------------------------------------------------
// pcda_stream_if
// valid/ready channel carrying one payload
// ---------------------------------------------------------------------------
interface pcda_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/perf_counter_delta_accumulator.sv =====
// ---------------------------------------------------------------------------
// perf_counter_delta_accumulator
// wrap-aware counter delta accumulation over pairs of counter reports
// ---------------------------------------------------------------------------
// The accumulators live in one ram (registered read). After reset a clearing
// pass writes every accumulator before the first request is taken; a clear
// request runs the same pass. An accumulate word is taken, then the ram is
// read, then the sum is written back; a read request reads the ram and then
// loads the result register. A waiting result holds off the input. The last
// word of a pair runs the tick scaling twice (start and end), each a multiply
// plus a 62-step shift-subtract divide; a rejected pair gives its result with
// no scaling. Results sit in an output register.
module perf_counter_delta_accumulator #(
   parameter int ACCUMULATOR_DEPTH = 62
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data,
   pcda_stream_if.sink   req,
   pcda_stream_if.source rsp
);
   localparam int AW = $clog2(ACCUMULATOR_DEPTH);

   pcda_pkg::state_type state_ff, state_in;
   pcda_pkg::req_type   cur_ff, cur_in;
   logic        fmt_ff;
   logic [31:0] freq_ff;
   logic        started_ff, started_in;
   logic [63:0] clock_ns_ff, clock_ns_in;
   logic [31:0] last_ticks_ff, last_ticks_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] last_ff, last_in;
   logic        rej_ff, rej_in;
   logic [31:0] pst_ff, pst_in;
   logic [31:0] pet_ff, pet_in;
   logic [1:0]  phase_ff, phase_in;
   logic [AW:0] clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pcda_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;
   logic [7:0]    slot;
   logic [6:0]    slot_ext;
   logic [63:0]   delta;
   logic [39:0]   d40;

   pcda_pkg::scale_req_type sreq;
   pcda_pkg::scale_rsp_type srsp;

   pcda_ram #(.Width(64), .Depth(ACCUMULATOR_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   pcda_scaler u_scaler (.clock(clock), .reset(reset), .req(sreq), .rsp(srsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= 1'b0;
         freq_ff <= pcda_pkg::TICK_FREQ_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pcda_pkg::CSR_REPORT_FORMAT: fmt_ff  <= csr_write_data[0];
            pcda_pkg::CSR_TICK_FREQ:     freq_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign slot     = pcda_pkg::slot_of(fmt_ff, cur_ff.word_pos);
   assign slot_ext = {1'b0, slot[5:0]};
   assign d40      = {cur_ff.end_high, cur_ff.end_word} - {cur_ff.start_high, cur_ff.start_word};
   assign delta    = slot[6] ? {24'd0, d40} : {32'd0, cur_ff.end_word - cur_ff.start_word};
   assign req.ready = (state_ff == pcda_pkg::ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      started_in    = started_ff;
      clock_ns_in   = clock_ns_ff;
      last_ticks_in = last_ticks_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      rej_in        = rej_ff;
      pst_in        = pst_ff;
      pet_in        = pet_ff;
      phase_in      = phase_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ff[AW-1:0];
      wr_data       = 64'd0;
      rd_addr       = slot[AW-1:0];
      sreq.start    = 1'b0;
      sreq.ticks    = 32'd0;
      sreq.freq     = freq_ff;
      unique case (state_ff)
         pcda_pkg::ST_INIT, pcda_pkg::ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(ACCUMULATOR_DEPTH - 1)) state_in = pcda_pkg::ST_IDLE;
         end
         pcda_pkg::ST_IDLE: begin
            clr_in = '0;
            if (req.valid && req.ready) begin
               cur_in = req.data;
               unique case (req.data.mode)
                  pcda_pkg::MODE_CLEAR: begin
                     first_in = 64'd0;
                     last_in  = 64'd0;
                     state_in = pcda_pkg::ST_CLEAR;
                  end
                  pcda_pkg::MODE_READ:  state_in = pcda_pkg::ST_READ_WAIT;
                  pcda_pkg::MODE_ACCUM: state_in = pcda_pkg::ST_ACC_WAIT;
                  default: ;
               endcase
            end
         end
         pcda_pkg::ST_READ_WAIT: begin
            rd_addr = cur_ff.counter_index[AW-1:0];
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else begin
               phase_in = 2'd0;
               rsp_in.accepted      = 1'b0;
               rsp_in.first_time_ns = first_ff;
               rsp_in.last_time_ns  = last_ff;
               rsp_in.counter_value = ({1'b0, cur_ff.counter_index} < 7'(ACCUMULATOR_DEPTH))
                                      ? rd_data : 64'd0;
               rsp_valid_in = 1'b1;
               state_in     = pcda_pkg::ST_IDLE;
            end
         end
         pcda_pkg::ST_ACC_WAIT: begin
            // timestamp latch happens in phase 0, the add and write back in phase 1
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
               if (cur_ff.word_pos == 6'd1) begin
                  pst_in = cur_ff.start_word;
                  pet_in = cur_ff.end_word;
                  rej_in = (cur_ff.start_word == 32'd0) || (cur_ff.end_word == 32'd0);
               end
            end else begin
               phase_in = 2'd0;
               wr_addr  = slot[AW-1:0];
               wr_data  = rd_data + delta;
               wr_en    = slot[7] && !rej_ff && (slot_ext < 7'(ACCUMULATOR_DEPTH));
               if (!cur_ff.last_word) begin
                  state_in = pcda_pkg::ST_IDLE;
               end else if (rej_ff) begin
                  rsp_in.accepted      = 1'b0;
                  rsp_in.first_time_ns = first_ff;
                  rsp_in.last_time_ns  = last_ff;
                  rsp_in.counter_value = 64'd0;
                  rsp_valid_in = 1'b1;
                  rej_in       = 1'b0;
                  state_in     = pcda_pkg::ST_IDLE;
               end else begin
                  state_in = pcda_pkg::ST_SCALE_INIT;
               end
            end
         end
         pcda_pkg::ST_SCALE_INIT: begin
            // phase 0: start-tick advance, phase 1: end-tick advance, phase 2: initial clock set from the start ticks
            if (!started_ff) begin
               started_in    = 1'b1;
               clock_ns_in   = 64'd0;
               last_ticks_in = pst_ff;
               sreq.start    = 1'b1;
               sreq.ticks    = pst_ff;
               phase_in      = 2'd2;
            end else begin
               sreq.start = 1'b1;
               sreq.ticks = ((phase_ff == 2'd1) ? pet_ff : pst_ff) - last_ticks_ff;
               last_ticks_in = (phase_ff == 2'd1) ? pet_ff : pst_ff;
            end
            state_in = pcda_pkg::ST_SCALE_DIV;
         end
         pcda_pkg::ST_SCALE_DIV: begin
            if (srsp.done) begin
               clock_ns_in = clock_ns_ff + srsp.ns;
               state_in    = pcda_pkg::ST_SCALE_ADD;
            end
         end
         pcda_pkg::ST_SCALE_ADD: begin
            if (phase_ff == 2'd2) begin
               // initial clock set; the zero-delta advance adds nothing
               phase_in = 2'd0;
               if (first_ff == 64'd0) first_in = clock_ns_ff;
               phase_in = 2'd1;
               state_in = pcda_pkg::ST_SCALE_INIT;
            end else if (phase_ff == 2'd0) begin
               if (first_ff == 64'd0) first_in = clock_ns_ff;
               phase_in = 2'd1;
               state_in = pcda_pkg::ST_SCALE_INIT;
            end else begin
               phase_in = 2'd0;
               last_in  = clock_ns_ff;
               state_in = pcda_pkg::ST_RESP;
            end
         end
         pcda_pkg::ST_RESP: begin
            rsp_in.accepted      = 1'b1;
            rsp_in.first_time_ns = first_ff;
            rsp_in.last_time_ns  = last_ff;
            rsp_in.counter_value = 64'd0;
            rsp_valid_in = 1'b1;
            rej_in       = 1'b0;
            state_in     = pcda_pkg::ST_IDLE;
         end
         default: state_in = pcda_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcda_pkg::ST_INIT;
         started_ff    <= 1'b0;
         clock_ns_ff   <= 64'd0;
         last_ticks_ff <= 32'd0;
         first_ff      <= 64'd0;
         last_ff       <= 64'd0;
         rej_ff        <= 1'b0;
         pst_ff        <= 32'd0;
         pet_ff        <= 32'd0;
         phase_ff      <= 2'd0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         clock_ns_ff   <= clock_ns_in;
         last_ticks_ff <= last_ticks_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         rej_ff        <= rej_in;
         pst_ff        <= pst_in;
         pet_ff        <= pet_in;
         phase_ff      <= phase_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

`include "perf_counter_delta_accumulator_defines.svh"

   `PCDA_ASSERT_IMP(a_busy, clock, reset, state_ff != pcda_pkg::ST_IDLE, !req.ready, "busy")
   `PCDA_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, !req.ready, "held")
   `PCDA_ASSERT_IMP(a_acc_clk, clock, reset, rsp.valid && rsp.data.accepted, started_ff, "clk")
endmodule

// ===== rtl/pcda_ram.sv =====
// ---------------------------------------------------------------------------
// pcda_ram
// single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module pcda_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/pcda_scaler.sv =====
// ---------------------------------------------------------------------------
// pcda_scaler
// ticks * 1e9 / freq, a 32x30 multiply then a bit-serial divide
// ---------------------------------------------------------------------------
module pcda_scaler (
   input  logic                   clock,
   input  logic                   reset,
   input  pcda_pkg::scale_req_type req,
   output pcda_pkg::scale_rsp_type rsp
);
   logic [61:0] dividend_ff, dividend_in;
   logic [31:0] divisor_ff, divisor_in;
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      trial       = {rem_ff[31:0], dividend_ff[61]};
      if (req.start) begin
         dividend_in = 62'(req.ticks) * 62'(pcda_pkg::NS_PER_SEC);
         divisor_in  = (req.freq == 32'd0) ? 32'd1 : req.freq;
         rem_in      = 33'd0;
         count_in    = 6'd0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         // restoring divide, one quotient bit per cycle into the dividend
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in      = trial - {1'b0, divisor_ff};
            dividend_in = {dividend_ff[60:0], 1'b1};
         end else begin
            rem_in      = trial;
            dividend_in = {dividend_ff[60:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd61) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 6'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ns   = {2'b00, dividend_ff};
endmodule

// ===== tb/pcda_delta_checker.sv =====
// ---------------------------------------------------------------------------
// pcda_delta_checker
// tracks the counter delta accumulator from its ports and checks every
// result transfer against its own prediction
// ---------------------------------------------------------------------------
module pcda_delta_checker #(
   parameter int ACCUMULATOR_DEPTH = 62
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [31:0]       csr_write_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pcda_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  pcda_pkg::rsp_type rsp_data,
   output int                pending_results,
   output int                mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0] counters [ACCUMULATOR_DEPTH];
   logic        clk_running;
   logic [63:0] clk_ns;
   logic [31:0] prev_ticks;
   logic [63:0] first_ns;
   logic [63:0] latest_ns;
   logic        rejected;
   logic [31:0] start_ticks;
   logic [31:0] end_ticks;
   logic        layout;
   logic [31:0] tick_hz;

   pcda_pkg::rsp_type expected_results[$];

   function automatic logic [63:0] ticks_to_ns(logic [31:0] ticks);
      logic [63:0] hz;
      hz = (tick_hz == 32'd0) ? 64'd1 : {32'd0, tick_hz};
      return ({32'd0, ticks} * 64'd1000000000) / hz;
   endfunction

   task automatic advance_clock(logic [31:0] ticks);
      clk_ns = clk_ns + ticks_to_ns(ticks - prev_ticks);
      prev_ticks = ticks;
   endtask

   task automatic predict_report(pcda_pkg::req_type it);
      int                slot;
      logic              wide;
      logic [39:0]       delta;
      pcda_pkg::rsp_type res;
      slot = -1;
      wide = 1'b0;
      res = '0;
      if (it.mode == pcda_pkg::MODE_CLEAR) begin
         foreach (counters[i]) counters[i] = '0;
         first_ns = '0;
         latest_ns = '0;
      end else if (it.mode == pcda_pkg::MODE_READ) begin
         res.first_time_ns = first_ns;
         res.last_time_ns = latest_ns;
         res.counter_value = (it.counter_index < ACCUMULATOR_DEPTH) ?
                             counters[it.counter_index] : 64'd0;
         expected_results.push_back(res);
      end else if (it.mode == pcda_pkg::MODE_ACCUM) begin
         if (it.word_pos == 6'd1) begin
            start_ticks = it.start_word;
            end_ticks = it.end_word;
            rejected = (it.start_word == 0) || (it.end_word == 0);
         end
         if (it.word_pos == 6'd1) slot = 0;
         else if (layout) begin
            if (it.word_pos >= 3) slot = it.word_pos - 2;
         end else if (it.word_pos == 3) slot = 1;
         else if (it.word_pos >= 4 && it.word_pos <= 35) begin
            slot = it.word_pos - 2;
            wide = 1'b1;
         end else if (it.word_pos >= 36 && it.word_pos <= 39) slot = it.word_pos - 2;
         else if (it.word_pos >= 48) slot = it.word_pos - 10;
         if (!rejected && slot >= 0 && slot < ACCUMULATOR_DEPTH) begin
            if (wide)
               delta = {it.end_high, it.end_word} - {it.start_high, it.start_word};
            else
               delta = {8'd0, it.end_word - it.start_word};
            counters[slot] = counters[slot] + {24'd0, delta};
         end
         if (it.last_word) begin
            if (!rejected) begin
               if (!clk_running) begin
                  clk_running = 1'b1;
                  clk_ns = ticks_to_ns(start_ticks);
                  prev_ticks = start_ticks;
               end
               advance_clock(start_ticks);
               if (first_ns == 0) first_ns = clk_ns;
               advance_clock(end_ticks);
               latest_ns = clk_ns;
               res.accepted = 1'b1;
            end
            rejected = 1'b0;
            res.first_time_ns = first_ns;
            res.last_time_ns = latest_ns;
            expected_results.push_back(res);
         end
      end
   endtask

   always @(posedge clock) begin
      pcda_pkg::rsp_type want;
      if (reset) begin
         foreach (counters[i]) counters[i] = '0;
         clk_running = 1'b0;
         clk_ns = '0;
         prev_ticks = '0;
         first_ns = '0;
         latest_ns = '0;
         rejected = 1'b0;
         start_ticks = '0;
         end_ticks = '0;
         layout = 1'b0;
         tick_hz = pcda_pkg::TICK_FREQ_RESET;
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == pcda_pkg::CSR_REPORT_FORMAT) layout = csr_write_data[0];
            else tick_hz = csr_write_data;
         end
         if (req_valid && req_ready) predict_report(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transfer: %p", rsp_data);
            end else begin
               want = expected_results.pop_front();
               if (want.accepted !== rsp_data.accepted
                   || want.first_time_ns !== rsp_data.first_time_ns
                   || want.last_time_ns !== rsp_data.last_time_ns
                   || want.counter_value !== rsp_data.counter_value) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
      end
      pending_results = expected_results.size();
   end

endmodule

// ===== tb/tb_perf_counter_delta_accumulator.sv =====
// ---------------------------------------------------------------------------
// tb_perf_counter_delta_accumulator
// drives report pairs, clears and reads through the accumulator with random
// gaps and stalls under several layout and tick-rate settings
// ---------------------------------------------------------------------------
module tb_perf_counter_delta_accumulator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = pcda_pkg::CSR_REPORT_FORMAT;
   logic [31:0] csr_write_data = '0;
   int          pending_results;
   int          mismatch_count;
   int          quiet_cycles = 0;
   int          items_sent = 0;
   logic        hold_request = 1'b0;

   pcda_stream_if #(.payload_type(pcda_pkg::req_type)) req_ch ();
   pcda_stream_if #(.payload_type(pcda_pkg::rsp_type)) rsp_ch ();

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   perf_counter_delta_accumulator DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req(req_ch), .rsp(rsp_ch)
   );

   pcda_delta_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .pending_results(pending_results), .mismatch_count(mismatch_count)
   );

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
   endfunction

   task automatic send_item(pcda_pkg::req_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_fields(logic [1:0] mode, logic [5:0] pos, logic [31:0] sw,
                              logic [31:0] ew, logic [7:0] sh, logic [7:0] eh,
                              logic last, logic [5:0] idx);
      pcda_pkg::req_type it;
      it = '{mode: mode, word_pos: pos, start_word: sw, end_word: ew,
             start_high: sh, end_high: eh, last_word: last, counter_index: idx};
      send_item(it);
   endtask

   task automatic send_random(logic [1:0] mode, logic [5:0] pos, logic last);
      send_fields(mode, pos, $urandom, $urandom, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), last, 6'($urandom_range(0, 63)));
   endtask

   // a pair: timestamp word, one to seven counter words, last mark on the final one
   task automatic send_pair();
      int          words;
      logic [31:0] sw;
      logic [31:0] ew;
      words = $urandom_range(2, 8);
      sw = $urandom;
      ew = sw + 32'($urandom_range(1, 100000));
      case ($urandom_range(0, 9))
         0: sw = '0;
         1: ew = '0;
         default: ;
      endcase
      send_fields(pcda_pkg::MODE_ACCUM, 6'd1, sw, ew, 8'($urandom), 8'($urandom), 1'b0,
                  6'($urandom));
      for (int i = 1; i < words; i++)
         send_random(pcda_pkg::MODE_ACCUM, 6'($urandom_range(0, 63)), i == words - 1);
   endtask

   task automatic write_register(logic index, logic [31:0] value);
      req_ch.valid <= 1'b0;
      wait (pending_results == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(int count);
      int start_count;
      start_count = items_sent;
      while (items_sent - start_count < count) begin
         case ($urandom_range(0, 9))
            0, 1: send_random(pcda_pkg::MODE_READ, 6'($urandom), 1'($urandom));
            2: send_random(2'($urandom_range(0, 3)), 6'($urandom), 1'($urandom));
            default: send_pair();
         endcase
      end
   endtask

   // receiver: random ready gaps, one long hold-off on request
   initial begin
      int gap;
      logic held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            gap = draw_gap();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reads at the index extremes, unused mode, clear
      send_fields(pcda_pkg::MODE_READ, 6'd0, '0, '0, '0, '0, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_NONE, 6'd1, '1, '1, '1, '1, 1'b1, 6'd63);
      // full-range pair with wrapping deltas
      send_fields(pcda_pkg::MODE_ACCUM, 6'd1, 32'd1, '1, '0, '0, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd3, '1, 32'd0, '0, '0, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd4, '1, 32'd0, 8'hff, 8'h00, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd35, 32'd0, '1, 8'h00, 8'hff, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd36, 32'd5, 32'd3, '1, '1, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd40, 32'd1, 32'd9, '0, '0, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd63, '0, '1, '0, '0, 1'b1, 6'd0);
      send_fields(pcda_pkg::MODE_READ, 6'd0, '0, '0, '0, '0, 1'b0, 6'd2);
      send_fields(pcda_pkg::MODE_READ, 6'd0, '0, '0, '0, '0, 1'b0, 6'd61);
      send_fields(pcda_pkg::MODE_READ, 6'd0, '0, '0, '0, '0, 1'b0, 6'd62);
      // pair with no timestamp word reuses latched ticks
      send_fields(pcda_pkg::MODE_ACCUM, 6'd0, '1, '0, '0, '0, 1'b1, 6'd0);
      // zero start timestamp, then zero end timestamp
      send_fields(pcda_pkg::MODE_ACCUM, 6'd1, 32'd0, 32'd7, '0, '0, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd3, 32'd1, 32'd8, '0, '0, 1'b1, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd1, 32'd7, 32'd0, '0, '0, 1'b1, 6'd0);
      send_fields(pcda_pkg::MODE_READ, 6'd0, '0, '0, '0, '0, 1'b0, 6'd1);
      send_fields(pcda_pkg::MODE_CLEAR, 6'd0, '0, '0, '0, '0, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_READ, 6'd0, '0, '0, '0, '0, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd1, 32'd100, 32'd200, '0, '0, 1'b1, 6'd0);

      write_register(pcda_pkg::CSR_REPORT_FORMAT, 32'd1);
      write_register(pcda_pkg::CSR_TICK_FREQ, 32'd1);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd1, '1, 32'd1, '0, '0, 1'b0, 6'd0);
      send_fields(pcda_pkg::MODE_ACCUM, 6'd63, 32'd1, 32'd2, '0, '0, 1'b1, 6'd0);
      random_phase(70);

      // long receiver hold-off while reads wait at the input
      hold_request <= 1'b1;
      repeat (12) send_random(pcda_pkg::MODE_READ, 6'd0, 1'b0);

      write_register(pcda_pkg::CSR_REPORT_FORMAT, 32'd0);
      write_register(pcda_pkg::CSR_TICK_FREQ, 32'hffffffff);
      random_phase(70);
      write_register(pcda_pkg::CSR_REPORT_FORMAT, 32'd1);
      write_register(pcda_pkg::CSR_TICK_FREQ, 32'd0);
      random_phase(70);
      write_register(pcda_pkg::CSR_REPORT_FORMAT, 32'($urandom_range(0, 1)));
      write_register(pcda_pkg::CSR_TICK_FREQ, $urandom);
      random_phase(70);
      write_register(pcda_pkg::CSR_TICK_FREQ, pcda_pkg::TICK_FREQ_RESET);
      random_phase(60);

      req_ch.valid <= 1'b0;
      wait (pending_results == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
